@@ hw/rtl/aesbc_pkg.sv @@
package aesbc_pkg;

  localparam int unsigned RoundKeyCount = 11;
  localparam int unsigned LastRound     = RoundKeyCount - 1;
  localparam int unsigned KeyIdxW       = $clog2(RoundKeyCount);

  typedef logic [KeyIdxW-1:0] key_idx_t;

  // byte 0 of the block is element 0, the most significant byte
  typedef logic [0:15][7:0] aes_state_t;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1
  } aesbc_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_HOLD
  } aesbc_state_e;

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } aesbc_in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } aesbc_out_t;

  // round key store write from the key schedule
  typedef struct packed {
    logic         en;
    key_idx_t     idx;
    logic [127:0] rkey;
  } aesbc_rk_wr_t;

  localparam logic [0:3][3:0] MixFwd = {4'd2, 4'd3, 4'd1, 4'd1};
  localparam logic [0:3][3:0] MixInv = {4'd14, 4'd11, 4'd13, 4'd9};

  localparam logic [0:255][7:0] SboxFwd = {
    128'h637c777bf26b6fc53001672bfed7ab76,
    128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115,
    128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84,
    128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8,
    128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973,
    128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479,
    128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
    128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df,
    128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] SboxInv = {
    128'h52096ad53036a538bf40a39e81f3d7fb,
    128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e,
    128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692,
    128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506,
    128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673,
    128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b,
    128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f,
    128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961,
    128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    return SboxFwd[x];
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] x);
    return SboxInv[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ hw/rtl/aesbc_round.sv @@
module aesbc_round import aesbc_pkg::*; (
  input  aes_state_t st_i,
  input  aes_state_t rk_i,
  input  logic       inv_i,
  input  logic       last_i,
  output aes_state_t st_o
);

  // multiply by a small constant in GF(2^8)
  function automatic logic [7:0] gmul_c(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) acc = acc ^ p;
      p = xtime(p);
    end
    return acc;
  endfunction

  function automatic aes_state_t mix(input aes_state_t s, input logic [0:3][3:0] row0);
    aes_state_t t;
    logic [7:0] acc;
    logic [1:0] k;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int i = 0; i < 4; i++) begin
          k   = 2'(i - r);
          acc = acc ^ gmul_c(s[4*c+i], row0[k]);
        end
        t[4*c+r] = acc;
      end
    end
    return t;
  endfunction

  aes_state_t fwd_sb, fwd_sh, fwd_out;
  aes_state_t inv_sh, inv_sb, inv_ak, inv_out;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      fwd_sb[i] = sbox_fwd(st_i[i]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fwd_sh[4*c+r]               = fwd_sb[4*((c+r)&3)+r];
        inv_sh[4*((c+r)&3)+r]       = st_i[4*c+r];
      end
    end
    for (int i = 0; i < 16; i++) begin
      inv_sb[i] = sbox_inv(inv_sh[i]);
    end
    // last round skips the column mix in both directions
    fwd_out = (last_i ? fwd_sh : mix(fwd_sh, MixFwd)) ^ rk_i;
    inv_ak  = inv_sb ^ rk_i;
    inv_out = last_i ? inv_ak : mix(inv_ak, MixInv);
  end

  assign st_o = inv_i ? inv_out : fwd_out;

endmodule

@@ hw/rtl/aesbc_keyexp.sv @@
module aesbc_keyexp import aesbc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  logic [127:0] key_i,
  output logic         busy_o,
  output aesbc_rk_wr_t wr_o
);

  logic [127:0] wk_q, wk_d;
  logic [7:0]   rcon_q, rcon_d;
  key_idx_t     cnt_q, cnt_d;
  logic         busy_q, busy_d;

  logic [31:0]  w3, t;
  logic [31:0]  n0, n1, n2, n3;

  always_comb begin
    w3 = wk_q[31:0];
    t  = {sbox_fwd(w3[23:16]) ^ rcon_q, sbox_fwd(w3[15:8]),
          sbox_fwd(w3[7:0]), sbox_fwd(w3[31:24])};
    n0 = wk_q[127:96] ^ t;
    n1 = wk_q[95:64]  ^ n0;
    n2 = wk_q[63:32]  ^ n1;
    n3 = wk_q[31:0]   ^ n2;
  end

  // a new load restarts the schedule from round key 0
  always_comb begin
    wk_d   = wk_q;
    rcon_d = rcon_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load_i) begin
      wk_d   = key_i;
      rcon_d = 8'h01;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      wk_d   = {n0, n1, n2, n3};
      rcon_d = xtime(rcon_q);
      cnt_d  = cnt_q + key_idx_t'(1);
      if (cnt_q == key_idx_t'(LastRound)) busy_d = 1'b0;
    end
  end

  // reset expands the all-zero key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_q   <= '0;
      rcon_q <= 8'h01;
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      wk_q   <= wk_d;
      rcon_q <= rcon_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o = busy_q;
  assign wr_o   = '{en: busy_q, idx: cnt_q, rkey: wk_q};

endmodule

@@ hw/rtl/aes128_block_cipher_core.sv @@
// Channel   Dir  Handshake                     Word
// in        in   in_valid_i / in_ready_o       aesbc_in_t  (cmd, block_high, block_low)
// out       out  out_valid_o / out_ready_i     aesbc_out_t (out_high, out_low)
// cfg       in   cfg_we_i, cfg_idx_i           cfg_data_i (key_high, key_low)
//
// One word runs from accept to result as the first key add in ST_INIT, then the
// rounds in ST_ROUND, each round key read from the key store a state ahead. The
// next word is taken in ST_IDLE, reached after the last round (via ST_HOLD while
// the output is full). After reset and after every key write the schedule fills
// the store; in_ready_o stays low meanwhile. A result waiting on out_ready_i
// holds the datapath only once the next word has run to its last round.
module aes128_block_cipher_core import aesbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  aesbc_in_t   in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output aesbc_out_t  out_word_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]  key_high_q, key_high_d;
  logic [63:0]  key_low_q, key_low_d;
  logic         kx_load;
  logic         kx_busy;
  aesbc_rk_wr_t rk_wr;

  always_comb begin
    key_high_d = key_high_q;
    key_low_d  = key_low_q;
    kx_load    = 1'b0;
    if (cfg_we_i) begin
      unique case (aesbc_reg_e'(cfg_idx_i))
        REG_KEY_HIGH: begin
          key_high_d = cfg_data_i;
          kx_load    = 1'b1;
        end
        REG_KEY_LOW: begin
          key_low_d = cfg_data_i;
          kx_load   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else begin
      key_high_q <= key_high_d;
      key_low_q  <= key_low_d;
    end
  end

  aesbc_keyexp u_keyexp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (kx_load),
    .key_i  ({key_high_d, key_low_d}),
    .busy_o (kx_busy),
    .wr_o   (rk_wr)
  );

  // round key store, one entry per round key, split in halves
  logic [63:0] rk_hi_mem [RoundKeyCount];
  logic [63:0] rk_lo_mem [RoundKeyCount];
  logic        rd_en;
  key_idx_t    rd_idx;
  aes_state_t  rk_q;

  always_ff @(posedge clk_i) begin
    if (rk_wr.en) begin
      rk_hi_mem[rk_wr.idx] <= rk_wr.rkey[127:64];
      rk_lo_mem[rk_wr.idx] <= rk_wr.rkey[63:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rk_q <= {rk_hi_mem[rd_idx], rk_lo_mem[rd_idx]};
  end

  aesbc_state_e state_q, state_d;
  aes_state_t   st_q, st_d;
  aes_state_t   round_out;
  logic         cmd_q, cmd_d;
  key_idx_t     kidx_q, kidx_d;
  key_idx_t     rnd_q, rnd_d;
  key_idx_t     step_idx;
  logic         in_acc, slot_free, last_rnd;
  logic         out_load;
  aesbc_out_t   out_d, out_q;
  logic         out_valid_q;

  assign in_ready_o = (state_q == ST_IDLE) && !kx_busy;
  assign in_acc     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign last_rnd   = rnd_q == key_idx_t'(LastRound);
  // decrypt walks the store downward
  assign step_idx   = cmd_q ? kidx_q - key_idx_t'(1) : kidx_q + key_idx_t'(1);

  aesbc_round u_round (
    .st_i   (st_q),
    .rk_i   (rk_q),
    .inv_i  (cmd_q),
    .last_i (last_rnd),
    .st_o   (round_out)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_INIT;
      ST_INIT:  state_d = ST_ROUND;
      ST_ROUND: if (last_rnd) state_d = slot_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en    = 1'b0;
    rd_idx   = kidx_q;
    kidx_d   = kidx_q;
    rnd_d    = rnd_q;
    st_d     = st_q;
    cmd_d    = cmd_q;
    out_load = 1'b0;
    out_d    = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rd_en  = 1'b1;
          rd_idx = in_word_i.cmd ? key_idx_t'(LastRound) : key_idx_t'(0);
          kidx_d = rd_idx;
          rnd_d  = '0;
          cmd_d  = in_word_i.cmd;
          st_d   = aes_state_t'({in_word_i.block_high, in_word_i.block_low});
        end
      end
      ST_INIT: begin
        st_d   = st_q ^ rk_q;
        rd_en  = 1'b1;
        rd_idx = step_idx;
        kidx_d = step_idx;
        rnd_d  = key_idx_t'(1);
      end
      ST_ROUND: begin
        st_d  = round_out;
        rnd_d = rnd_q + key_idx_t'(1);
        if (!last_rnd) begin
          rd_en  = 1'b1;
          rd_idx = step_idx;
          kidx_d = step_idx;
        end else if (slot_free) begin
          out_load = 1'b1;
          out_d    = aesbc_out_t'(round_out);
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_d    = aesbc_out_t'(st_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kidx_q      <= '0;
      rnd_q       <= '0;
      cmd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kidx_q  <= kidx_d;
      rnd_q   <= rnd_d;
      cmd_q   <= cmd_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
